@@ hw/rtl/idiv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idiv_pkg: shared types for the integer divider
// Transaction payloads, controller state encoding and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package idiv_pkg;

  // Width of every operand and result field on the ports.
  localparam int unsigned FIELD_W = 64;

  // Request transaction: mode selects unsigned (0) or signed (1) division.
  typedef struct packed {
    logic               mode;
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
  } idiv_req_t;

  // Response transaction.
  typedef struct packed {
    logic [FIELD_W-1:0] quotient;
    logic [FIELD_W-1:0] remainder;
    logic               divide_by_zero;
  } idiv_rsp_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIX
  } idiv_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } idiv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_zero;
  } idiv_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/idiv_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idiv_dpath: restoring divider datapath
// Holds the operand magnitudes, the partial remainder and the quotient shift
// register, performs one subtract step per cycle and applies the signs into
// the response register.
// ----------------------------------------------------------------------------
module idiv_dpath #(
  parameter int unsigned Width = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire idiv_pkg::idiv_cmd_t  cmd_i,
  output      idiv_pkg::idiv_stat_t stat_o,
  input  wire idiv_pkg::idiv_req_t  req_i,
  output      idiv_pkg::idiv_rsp_t  rsp_o
);

  logic [Width-1:0] num_q, num_d;
  logic [Width-1:0] den_q, den_d;
  logic [Width-1:0] rem_q, rem_d;
  logic             qneg_q, qneg_d;
  logic             rneg_q, rneg_d;
  logic             dz_q, dz_d;
  idiv_pkg::idiv_rsp_t rsp_q, rsp_d;

  logic [Width-1:0] op_n, op_d;
  logic             n_neg, d_neg;
  logic [Width:0]   shifted, diff;
  logic [Width-1:0] r_src;

  // Operand magnitudes at load time.
  always_comb begin
    op_n  = req_i.dividend[Width-1:0];
    op_d  = req_i.divisor[Width-1:0];
    n_neg = req_i.mode & op_n[Width-1];
    d_neg = req_i.mode & op_d[Width-1];
  end

  // One restoring step: shift in the next dividend bit and trial subtract.
  always_comb begin
    shifted = {rem_q, num_q[Width-1]};
    diff    = shifted - {1'b0, den_q};
  end

  // Working register updates.
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    dz_d   = dz_q;
    if (cmd_i.load) begin
      num_d  = n_neg ? (Width'(0) - op_n) : op_n;
      den_d  = d_neg ? (Width'(0) - op_d) : op_d;
      rem_d  = '0;
      qneg_d = n_neg ^ d_neg;
      rneg_d = n_neg;
      dz_d   = (op_d == '0);
    end else if (cmd_i.step) begin
      if (!diff[Width]) begin
        rem_d = diff[Width-1:0];
        num_d = {num_q[Width-2:0], 1'b1};
      end else begin
        rem_d = shifted[Width-1:0];
        num_d = {num_q[Width-2:0], 1'b0};
      end
    end
  end

  // Sign correction and zero divisor convention into the response register.
  // On a zero divisor no step runs, so the magnitude of the dividend is still
  // in the quotient register and restoring its sign gives the dividend back.
  always_comb begin
    rsp_d = rsp_q;
    r_src = dz_q ? num_q : rem_q;
    if (cmd_i.finish) begin
      if (dz_q) begin
        rsp_d.quotient = idiv_pkg::FIELD_W'({Width{1'b1}});
      end else begin
        rsp_d.quotient = idiv_pkg::FIELD_W'(qneg_q ? (Width'(0) - num_q) : num_q);
      end
      rsp_d.remainder      = idiv_pkg::FIELD_W'(rneg_q ? (Width'(0) - r_src) : r_src);
      rsp_d.divide_by_zero = dz_q;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    rsp_q <= rsp_d;
  end

  // Flags are control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qneg_q <= 1'b0;
      rneg_q <= 1'b0;
      dz_q   <= 1'b0;
    end else begin
      qneg_q <= qneg_d;
      rneg_q <= rneg_d;
      dz_q   <= dz_d;
    end
  end

  assign stat_o.div_zero = dz_q;
  assign rsp_o           = rsp_q;

  // The remainder stays below the divisor during every step.
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> (rem_q < den_q))
    else $error("partial remainder not below divisor");

  // A load with a zero divisor raises the zero flag.
  a_dz_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && (req_i.divisor[Width-1:0] == '0)) |=> dz_q)
    else $error("zero divisor not flagged");

  // A zero divisor returns all ones as the quotient and raises the response flag.
  a_dz_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && dz_q) |=>
      (rsp_q.divide_by_zero && (rsp_q.quotient[Width-1:0] == {Width{1'b1}})))
    else $error("zero divisor response malformed");

endmodule
`default_nettype wire

@@ hw/rtl/idiv_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idiv_ctrl: divider sequencer
// Accepts a request, counts the subtract steps, triggers the final sign fix
// and manages the valid flag of the response register.
// ----------------------------------------------------------------------------
module idiv_ctrl #(
  parameter int unsigned Width = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      idiv_pkg::idiv_cmd_t  cmd_o,
  input  wire idiv_pkg::idiv_stat_t stat_i
);

  localparam int unsigned CntW = $clog2(Width);

  idiv_pkg::idiv_state_e state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic                  last_step;
  logic                  out_free;

  assign last_step = (cnt_q == CntW'(Width - 1));
  assign out_free  = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      idiv_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = idiv_pkg::ST_CALC;
      end
      idiv_pkg::ST_CALC: begin
        if (stat_i.div_zero || last_step) state_d = idiv_pkg::ST_FIX;
      end
      idiv_pkg::ST_FIX: begin
        if (out_free) state_d = idiv_pkg::ST_IDLE;
      end
      default: state_d = idiv_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      idiv_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      idiv_pkg::ST_CALC: begin
        cmd_o.step = !stat_i.div_zero;
      end
      idiv_pkg::ST_FIX: begin
        cmd_o.finish = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Step counter and response valid flag.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_o.load) begin
      cnt_d = '0;
    end else if (cmd_o.step) begin
      cnt_d = cnt_q + CntW'(1);
    end
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= idiv_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // An accepted transaction starts the step sequence at count zero.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == idiv_pkg::ST_CALC) && (cnt_q == '0))
    else $error("calculation did not start cleanly");

  // A pending response is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("response register overwritten");

  // The last step leads to the fix state.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == idiv_pkg::ST_CALC && last_step) |=> (state_q == idiv_pkg::ST_FIX))
    else $error("step count overran");

  // Only one command at a time.
  a_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.finish}))
    else $error("conflicting datapath commands");

endmodule
`default_nettype wire

@@ hw/rtl/int64_divide_signed_unsigned_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int64_divide_signed_unsigned_core: radix-2 restoring integer divider
// Unsigned or two's-complement signed division returning quotient and
// remainder in one response transaction.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction (mode, dividend, divisor) is taken on the in_* channel
//   while the divider is idle. One response transaction (quotient, remainder,
//   divide_by_zero) follows on the out_* channel for each request.
//   Operands are DATA_WIDTH bits wide (capped at 64); upper field bits are
//   ignored and results are zero extended to the field width.
//   Timing: one quotient bit is produced per cycle by the shared subtractor; a
//   transaction passes through a load, one step per quotient bit and one sign
//   fix, and a zero divisor skips the steps. The response becomes valid as the
//   divider returns to idle, and the next request can be accepted in that
//   same cycle.
//   The response sits in its own register, so a new request is accepted and
//   divided while a finished response waits; if the receiver still stalls at
//   the end of that division, the divider holds in its fix state.
//   Reset clears the controller and the response valid flag; nothing is pending.
// ----------------------------------------------------------------------------
module int64_divide_signed_unsigned_core #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire idiv_pkg::idiv_req_t in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      idiv_pkg::idiv_rsp_t out_data_o
);

  localparam int unsigned EffW = (DATA_WIDTH > idiv_pkg::FIELD_W) ?
                                 idiv_pkg::FIELD_W : DATA_WIDTH;

  idiv_pkg::idiv_cmd_t  cmd;
  idiv_pkg::idiv_stat_t stat;

  // Sequencer.
  idiv_ctrl #(
    .Width (EffW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Arithmetic.
  idiv_dpath #(
    .Width (EffW)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .req_i  (in_data_i),
    .rsp_o  (out_data_o)
  );

endmodule
`default_nettype wire
